// ===== hdl/gcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gcsc_pkg
// Shared types and constants of the grid corner straightness checker.
// ----------------------------------------------------------------------------
package gcsc_pkg;

  // Configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam int unsigned CFG_BITS = 7;

  localparam logic [CFG_BITS-1:0] GRID_WIDTH_RST  = 7'd9;
  localparam logic [CFG_BITS-1:0] GRID_HEIGHT_RST = 7'd6;

  // 0.993^2 * 2^20, truncated
  localparam int unsigned SCALE_SHIFT = 20;
  localparam logic [19:0] COS2_SCALED = 20'd1033947;

  // Multiplier digit size, bits of the second operand consumed per cycle
  localparam int unsigned DIG_BITS = 8;

  localparam int unsigned ROW_MAX = 127;

  typedef struct packed {
    logic row_chk;
    logic col_chk;
    logic last;
    logic mismatch;
  } job_flags_t;

  localparam int unsigned FLAG_BITS = $bits(job_flags_t);

endpackage

// ===== hdl/grid_corner_straightness_check_top.sv =====
// ----------------------------------------------------------------------------
// grid_corner_straightness_check_top
// Checks that chessboard corners lie on straight rows and columns.
//
// Corners enter on the in_ stream in raster order; in_tlast marks the final
// corner of a grid. For each corner the row triple (two left neighbors) and
// the column triple (two corners above, from the row buffers) are tested for
// |cos| >= 0.993. One verdict per grid leaves on the out_ stream.
// The front takes a new corner only once the queue has taken the last one,
// and does the row buffer read and write. The back works on one corner at a
// time: per triple it runs nine multiplications on the shared multiplier,
// one 8-bit digit of the second operand at a time, then a compare. out_tvalid
// rises once the back has finished the last corner of a grid.
// A two-entry queue decouples front and back. A stalled out_ stream holds the
// verdict in its output register; the back then stops before the next
// verdict and the queue fills, which drops in_tready.
// Reset restores width 9 and height 6 and clears the counters; the row
// buffers are not cleared. cfg_ready is always high.
// ----------------------------------------------------------------------------
module grid_corner_straightness_check_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int COORD_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [gcsc_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // point_x, point_y, zero fill
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // grid_ok, count_mismatch, zero fill
  output logic [7:0]                           out_tdata
);
  import gcsc_pkg::*;

  localparam int PT = 2 * COORD_BITS;
  localparam int QW = FLAG_BITS + 5 * PT;

  logic            job_valid, job_ready, q_valid, q_ready;
  job_flags_t      job_flags;
  logic [PT-1:0]   job_p0r, job_p1r, job_p0c, job_p1c, job_p2;
  logic [QW-1:0]   q_in, q_out;
  logic            ok, mismatch;

  assign cfg_ready = 1'b1;

  gcsc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_point (in_tdata[PT-1:0]),
    .in_last  (in_tlast),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job_flags(job_flags),
    .job_p0r  (job_p0r),
    .job_p1r  (job_p1r),
    .job_p0c  (job_p0c),
    .job_p1c  (job_p1c),
    .job_p2   (job_p2)
  );

  assign q_in = {job_flags, job_p2, job_p1c, job_p0c, job_p1r, job_p0r};

  gcsc_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(job_valid),
    .push_ready(job_ready),
    .push_data (q_in),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_out)
  );

  gcsc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .job_flags   (job_flags_t'(q_out[QW-1 -: FLAG_BITS])),
    .job_p0r     (q_out[PT-1:0]),
    .job_p1r     (q_out[2*PT-1:PT]),
    .job_p0c     (q_out[3*PT-1:2*PT]),
    .job_p1c     (q_out[4*PT-1:3*PT]),
    .job_p2      (q_out[5*PT-1:4*PT]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_ok      (ok),
    .out_mismatch(mismatch)
  );

  assign out_tdata = {6'd0, mismatch, ok};

endmodule

// ===== hdl/gcsc_front.sv =====
// ----------------------------------------------------------------------------
// gcsc_front
// Takes corners, tracks grid position and point count, keeps the two row
// buffers and hands each corner with its neighbor points to the queue.
// ----------------------------------------------------------------------------
module gcsc_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic                         cfg_index,
  input  logic [gcsc_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2*COORD_BITS-1:0]      in_point,
  input  logic                         in_last,
  output logic                         job_valid,
  input  logic                         job_ready,
  output gcsc_pkg::job_flags_t         job_flags,
  output logic [2*COORD_BITS-1:0]      job_p0r,
  output logic [2*COORD_BITS-1:0]      job_p1r,
  output logic [2*COORD_BITS-1:0]      job_p0c,
  output logic [2*COORD_BITS-1:0]      job_p1c,
  output logic [2*COORD_BITS-1:0]      job_p2
);
  import gcsc_pkg::*;

  localparam int PT        = 2 * COORD_BITS;
  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int CNT_LIMIT = MAX_WIDTH * MAX_HEIGHT + 1;
  localparam int CW        = $clog2(CNT_LIMIT + 1);

  typedef enum logic {F_IDLE, F_WRITE} fstate_t;

  fstate_t              state_r;
  logic [CFG_BITS-1:0]  cfg_w_r, cfg_h_r;
  logic [CFG_BITS-1:0]  col_r, row_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [PT-1:0]        prev_r, prev2_r;
  logic [PT-1:0]        cur_r, p0_r, p1_r, a1_q, a2_q;
  logic [AW-1:0]        addr_r;
  logic                 col_wr_r;
  job_flags_t           flags_r;

  logic [PT-1:0] above_mem  [MAX_WIDTH];
  logic [PT-1:0] above2_mem [MAX_WIDTH];

  logic          accept, wrap, col_in_buf;
  logic [13:0]   area;

  assign accept     = in_valid && (state_r == F_IDLE);
  assign wrap       = (8'(col_r) + 8'd1) >= 8'(cfg_w_r);
  assign col_in_buf = 32'(col_r) < MAX_WIDTH;
  assign area       = 14'(cfg_w_r) * 14'(cfg_h_r);
  assign cnt_nxt    = (cnt_r < CW'(CNT_LIMIT)) ? cnt_r + CW'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cfg_w_r <= GRID_WIDTH_RST;
      cfg_h_r <= GRID_HEIGHT_RST;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
      prev_r  <= '0;
      prev2_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  cfg_w_r <= cfg_data;
          CFG_GRID_HEIGHT: cfg_h_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            state_r <= F_WRITE;
            if (in_last || wrap) begin
              prev_r  <= '0;
              prev2_r <= '0;
              col_r   <= '0;
            end else begin
              prev_r  <= in_point;
              prev2_r <= prev_r;
              col_r   <= col_r + 7'd1;
            end
            if (in_last) begin
              row_r <= '0;
              cnt_r <= '0;
            end else begin
              cnt_r <= cnt_nxt;
              if (wrap && 32'(row_r) < ROW_MAX) row_r <= row_r + 7'd1;
            end
          end
        end
        F_WRITE: begin
          if (job_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r            <= in_point;
      p0_r             <= prev2_r;
      p1_r             <= prev_r;
      addr_r           <= AW'(col_r);
      col_wr_r         <= col_in_buf;
      flags_r.row_chk  <= col_r >= 7'd2;
      flags_r.col_chk  <= col_in_buf && (row_r >= 7'd2);
      flags_r.last     <= in_last;
      flags_r.mismatch <= 32'(cnt_nxt) != 32'(area);
    end
  end

  // Row buffers: read on accept, shift down one row when the item is handed on
  always_ff @(posedge clk) begin
    if (accept) begin
      a1_q <= above_mem[AW'(col_r)];
      a2_q <= above2_mem[AW'(col_r)];
    end
    if (state_r == F_WRITE && job_ready && col_wr_r) begin
      above_mem[addr_r]  <= cur_r;
      above2_mem[addr_r] <= a1_q;
    end
  end

  assign in_ready  = state_r == F_IDLE;
  assign job_valid = state_r == F_WRITE;
  assign job_flags = flags_r;
  assign job_p0r   = p0_r;
  assign job_p1r   = p1_r;
  assign job_p0c   = a2_q;
  assign job_p1c   = a1_q;
  assign job_p2    = cur_r;

endmodule

// ===== hdl/gcsc_fifo.sv =====
// ----------------------------------------------------------------------------
// gcsc_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module gcsc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import gcsc_pkg::*;

  logic [WIDTH-1:0] data_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) data_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hdl/gcsc_back.sv =====
// ----------------------------------------------------------------------------
// gcsc_back
// Runs the row and column triple checks of each corner on one shared
// digit-serial multiplier and delivers the grid verdict.
// ----------------------------------------------------------------------------
module gcsc_back #(
  parameter int COORD_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  output logic                    job_ready,
  input  gcsc_pkg::job_flags_t    job_flags,
  input  logic [2*COORD_BITS-1:0] job_p0r,
  input  logic [2*COORD_BITS-1:0] job_p1r,
  input  logic [2*COORD_BITS-1:0] job_p0c,
  input  logic [2*COORD_BITS-1:0] job_p1c,
  input  logic [2*COORD_BITS-1:0] job_p2,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_ok,
  output logic                    out_mismatch
);
  import gcsc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PT = 2 * CB;
  localparam int NW = 2 * CB + 1;
  localparam int LW = 4 * CB + 2;
  localparam int PW = LW + SCALE_SHIFT;
  localparam int BW = NW;

  typedef enum logic [2:0] {
    B_IDLE, B_PICK, B_SETUP, B_LOAD, B_MUL, B_CMP, B_FIN
  } bstate_t;

  typedef enum logic [3:0] {
    OP_AXBX, OP_AYBY, OP_NA0, OP_NA1, OP_NB0, OP_NB1, OP_LHS, OP_R, OP_RHS
  } op_t;

  function automatic logic [CB:0] step(input logic [CB-1:0] to, input logic [CB-1:0] from);
    step = (to < from) ? {1'b1, from - to} : {1'b0, to - from};
  endfunction

  bstate_t        state_r;
  op_t            op_r;
  logic           tsel_r, pend_row_r, pend_col_r, last_r, mis_r, fail_r;
  logic           out_valid_r, out_ok_r, out_mis_r, same_r;
  logic [PT-1:0]  p0r_r, p1r_r, p0c_r, p1c_r, p2_r;
  logic [CB-1:0]  ax_r, ay_r, bx_r, by_r;
  logic [PW-1:0]  areg_r, acc_r, acc_nxt, a_sel;
  logic [BW-1:0]  breg_r, b_rest, b_sel;
  logic [PT-1:0]  p1_r;
  logic [NW-1:0]  dot_r, na_r, nb_r, dot_nxt;
  logic [LW-1:0]  lhs_r, r_r;

  logic [PT-1:0]  s0, s1;
  logic [CB:0]    stx1, sty1, stx2, sty2;
  logic [PT-1:0]  p2_prod;
  logic           out_load;

  assign s0   = tsel_r ? p0c_r : p0r_r;
  assign s1   = tsel_r ? p1c_r : p1r_r;
  assign stx1 = step(s1[CB-1:0], s0[CB-1:0]);
  assign sty1 = step(s1[PT-1:CB], s0[PT-1:CB]);
  assign stx2 = step(p2_r[CB-1:0], s1[CB-1:0]);
  assign sty2 = step(p2_r[PT-1:CB], s1[PT-1:CB]);

  always_comb begin
    case (op_r)
      OP_AXBX: begin a_sel = PW'(ax_r);  b_sel = BW'(bx_r); end
      OP_AYBY: begin a_sel = PW'(ay_r);  b_sel = BW'(by_r); end
      OP_NA0:  begin a_sel = PW'(ax_r);  b_sel = BW'(ax_r); end
      OP_NA1:  begin a_sel = PW'(ay_r);  b_sel = BW'(ay_r); end
      OP_NB0:  begin a_sel = PW'(bx_r);  b_sel = BW'(bx_r); end
      OP_NB1:  begin a_sel = PW'(by_r);  b_sel = BW'(by_r); end
      OP_LHS:  begin a_sel = PW'(dot_r); b_sel = dot_r;     end
      OP_R:    begin a_sel = PW'(na_r);  b_sel = nb_r;      end
      OP_RHS:  begin a_sel = PW'(r_r);   b_sel = BW'(COS2_SCALED); end
      default: begin a_sel = '0;         b_sel = '0;        end
    endcase
  end

  // One digit of the second operand per cycle
  assign acc_nxt = acc_r + areg_r * PW'(breg_r[DIG_BITS-1:0]);
  assign b_rest  = breg_r >> DIG_BITS;
  assign p2_prod = acc_nxt[PT-1:0];

  always_comb begin
    if (same_r)              dot_nxt = NW'(p1_r) + NW'(p2_prod);
    else if (p1_r >= p2_prod) dot_nxt = NW'(p1_r - p2_prod);
    else                     dot_nxt = NW'(p2_prod - p1_r);
  end

  assign out_load = (state_r == B_FIN) && last_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_row_r  <= 1'b0;
      pend_col_r  <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            pend_row_r <= job_flags.row_chk;
            pend_col_r <= job_flags.col_chk;
            last_r     <= job_flags.last;
            mis_r      <= job_flags.mismatch;
            p0r_r      <= job_p0r;
            p1r_r      <= job_p1r;
            p0c_r      <= job_p0c;
            p1c_r      <= job_p1c;
            p2_r       <= job_p2;
            state_r    <= B_PICK;
          end
        end
        B_PICK: begin
          if (pend_row_r) begin
            tsel_r     <= 1'b0;
            pend_row_r <= 1'b0;
            state_r    <= B_SETUP;
          end else if (pend_col_r) begin
            tsel_r     <= 1'b1;
            pend_col_r <= 1'b0;
            state_r    <= B_SETUP;
          end else begin
            state_r <= B_FIN;
          end
        end
        B_SETUP: begin
          ax_r    <= stx1[CB-1:0];
          ay_r    <= sty1[CB-1:0];
          bx_r    <= stx2[CB-1:0];
          by_r    <= sty2[CB-1:0];
          same_r  <= (stx1[CB] ^ stx2[CB]) == (sty1[CB] ^ sty2[CB]);
          op_r    <= OP_AXBX;
          state_r <= B_LOAD;
        end
        B_LOAD: begin
          areg_r <= a_sel;
          breg_r <= b_sel;
          // second square of a norm accumulates onto the first
          if (op_r != OP_NA1 && op_r != OP_NB1) acc_r <= '0;
          state_r <= B_MUL;
        end
        B_MUL: begin
          acc_r  <= acc_nxt;
          areg_r <= areg_r << DIG_BITS;
          breg_r <= b_rest;
          if (b_rest == '0) begin
            case (op_r)
              OP_AXBX: p1_r  <= acc_nxt[PT-1:0];
              OP_AYBY: dot_r <= dot_nxt;
              OP_NA1:  na_r  <= acc_nxt[NW-1:0];
              OP_NB1:  nb_r  <= acc_nxt[NW-1:0];
              OP_LHS:  lhs_r <= acc_nxt[LW-1:0];
              OP_R:    r_r   <= acc_nxt[LW-1:0];
              default: ;
            endcase
            if (op_r == OP_RHS) begin
              state_r <= B_CMP;
            end else begin
              op_r    <= op_t'(op_r + 4'd1);
              state_r <= B_LOAD;
            end
          end
        end
        B_CMP: begin
          if ((PW'(lhs_r) << SCALE_SHIFT) < acc_r) fail_r <= 1'b1;
          state_r <= B_PICK;
        end
        B_FIN: begin
          if (!last_r) begin
            state_r <= B_IDLE;
          end else if (out_load) begin
            out_ok_r    <= !mis_r && !fail_r;
            out_mis_r   <= mis_r;
            fail_r      <= 1'b0;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign job_ready    = state_r == B_IDLE;
  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_mismatch = out_mis_r;

endmodule
